### design/rucp_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants for the rover uart command parser
// no dependencies

package rucp_pkg;

	localparam int LINE_DEPTH_DEF = 16;

	localparam int VALUE_W = 20;
	localparam logic [VALUE_W-1:0] VALUE_LIMIT = {VALUE_W{1'b1}};
	localparam int PROD_W = VALUE_W + 8;

	localparam int BYTE_W = 8;
	localparam int SPEED_W = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PCT_LOW,
		CFG_PCT_HIGH,
		CFG_PCT_SCALE,
		CFG_PWM_LOW,
		CFG_PWM_HIGH
	} cfg_idx_t;

	typedef enum logic [2:0] {
		DRV_FWD,
		DRV_BACK,
		DRV_LEFT,
		DRV_RIGHT,
		DRV_STOP
	} drive_t;

	localparam logic [BYTE_W-1:0] CH_V     = 8'h56;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
	localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
	localparam logic [BYTE_W-1:0] CH_L     = 8'h4C;
	localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
	localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
	localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
	localparam logic [BYTE_W-1:0] CH_P_LO  = 8'h70;
	localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
	localparam logic [BYTE_W-1:0] CH_H_LO  = 8'h68;
	localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
	localparam logic [BYTE_W-1:0] CH_O_LO  = 8'h6F;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCALE,
		ST_CHECK,
		ST_RESULT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SC_HEAD,
		SC_COLON,
		SC_SPACE,
		SC_DIGIT
	} scan_ph_t;

	typedef struct packed {
		logic take;
		logic step;
		logic scale;
		logic check;
		logic load;
	} rucp_cmd_t;

	typedef struct packed {
		logic line_end;
		logic scan_done;
	} rucp_stat_t;

endpackage

### design/rover_uart_command_parser_core.sv
`timescale 1ns / 1ps
// top level of the rover uart command parser: controller plus datapath
// depends on rucp_pkg, rucp_ctrl, rucp_dp
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_stall   | rx_byte
//   result  | out       | out_valid / out_stall | drive_command .. speed_rejected
//   config  | in        | cfg_we                | cfg_index, cfg_data
//
// a command letter or buffered byte is accepted, then the result is loaded
// a cr or lf walks the stored line one character per cycle through the scanner,
// then percent scaling, window check and result load follow in that order
// one byte at a time; the next byte is taken while the last result still waits
// a stalled result keeps the next result, and so the input, waiting; reset empties the buffer

module rover_uart_command_parser_core import rucp_pkg::*; #(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           drive_command,
	output logic                 pid_enabled,
	output logic                 horn_on,
	output logic                 link_online,
	output logic [SPEED_W-1:0]   motor_speed,
	output logic                 motor_refresh,
	output logic                 buzzer_refresh,
	output logic                 speed_applied,
	output logic                 speed_rejected,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	rucp_cmd_t  cmd;
	rucp_stat_t stat;

	rucp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	rucp_dp #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.rx_byte       (rx_byte),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.drive_command (drive_command),
		.pid_enabled   (pid_enabled),
		.horn_on       (horn_on),
		.link_online   (link_online),
		.motor_speed   (motor_speed),
		.motor_refresh (motor_refresh),
		.buzzer_refresh(buzzer_refresh),
		.speed_applied (speed_applied),
		.speed_rejected(speed_rejected)
	);

endmodule

### design/rucp_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies

module rucp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/rucp_ctrl.sv
`timescale 1ns / 1ps
// control state machine for the command parser
// depends on rucp_pkg

module rucp_ctrl import rucp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  rucp_stat_t stat,
	output rucp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = stat.line_end ? ST_SCAN : ST_RESULT;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
			end
			ST_RESULT: begin
				cmd.load = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### design/rucp_dp.sv
`timescale 1ns / 1ps
// datapath: command state, line buffer, number scanner, speed window checks
// depends on rucp_pkg and rucp_ram

module rucp_dp import rucp_pkg::*; #(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rucp_cmd_t            cmd,
	output rucp_stat_t           stat,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic [2:0]           drive_command,
	output logic                 pid_enabled,
	output logic                 horn_on,
	output logic                 link_online,
	output logic [SPEED_W-1:0]   motor_speed,
	output logic                 motor_refresh,
	output logic                 buzzer_refresh,
	output logic                 speed_applied,
	output logic                 speed_rejected
);

	localparam int ADDR_W = $clog2(LINE_DEPTH);
	localparam logic [ADDR_W-1:0] LEN_MAX = ADDR_W'(LINE_DEPTH - 1);

	logic [7:0]         pct_low_q, pct_high_q, pct_scale_q;
	logic [SPEED_W-1:0] pwm_low_q, pwm_high_q;

	logic [ADDR_W-1:0]  len_q;
	logic [2:0]         drive_q;
	logic               pid_q, horn_q, link_q;
	logic [SPEED_W-1:0] speed_q;
	logic               motor_p_q, buzz_p_q, app_p_q, rej_p_q;

	logic [ADDR_W-1:0]  pos_q;
	scan_ph_t           ph_q;
	logic [VALUE_W-1:0] mag_q;
	logic               neg_q, nov_q;
	logic [PROD_W-1:0]  v_q;

	logic [2:0]         drive_o_q;
	logic               pid_o_q, horn_o_q, link_o_q;
	logic [SPEED_W-1:0] speed_o_q;
	logic               motor_o_q, buzz_o_q, app_o_q, rej_o_q;

	logic               line_end, is_letter, ram_we;
	logic [BYTE_W-1:0]  ram_rdata, ch;
	logic [ADDR_W-1:0]  raddr;

	logic               is_ws, is_sign, is_digit;
	logic [3:0]         dig;
	logic [VALUE_W+3:0] acc;
	logic [VALUE_W-1:0] acc_sat;
	scan_ph_t           ph_d;
	logic               consume, done, nov_d, neg_d;
	logic [VALUE_W-1:0] mag_d;
	logic               pct_in, val_ok;

	// input byte classes
	assign line_end = (rx_byte == CH_CR) || (rx_byte == CH_LF);

	always_comb begin
		unique case (rx_byte) inside
			CH_F, CH_B, CH_L, CH_R, CH_S, CH_P, CH_P_LO, CH_H, CH_H_LO, CH_O, CH_O_LO: begin
				is_letter = 1'b1;
			end
			default: begin
				is_letter = 1'b0;
			end
		endcase
	end

	assign ram_we = cmd.take && !is_letter && !line_end && (len_q < LEN_MAX);

	rucp_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(LINE_DEPTH)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(len_q),
		.wdata(rx_byte),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// scanner, one stored character per step
	assign ch = (pos_q < len_q) ? ram_rdata : '0;
	assign is_ws = (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_VT) || (ch == CH_FF)
		|| (ch == CH_CR) || (ch == CH_LF);
	assign is_sign = (ch == CH_PLUS) || (ch == CH_MINUS);
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign dig = ch[3:0];
	assign acc = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {{VALUE_W{1'b0}}, dig};
	assign acc_sat = (acc > {4'b0000, VALUE_LIMIT}) ? VALUE_LIMIT : acc[VALUE_W-1:0];

	always_comb begin
		ph_d = ph_q;
		consume = 1'b0;
		done = 1'b0;
		nov_d = nov_q;
		neg_d = neg_q;
		mag_d = mag_q;
		if (ph_q == SC_HEAD) begin
			if (ch == CH_V) begin
				ph_d = SC_COLON;
				consume = 1'b1;
			end else begin
				nov_d = 1'b1;
				done = 1'b1;
			end
		end else if (ph_q == SC_DIGIT) begin
			if (is_digit) begin
				mag_d = acc_sat;
				consume = 1'b1;
			end else begin
				done = 1'b1;
			end
		end else if ((ph_q == SC_COLON) && (ch == CH_COLON)) begin
			ph_d = SC_SPACE;
			consume = 1'b1;
		end else if (is_ws) begin
			ph_d = SC_SPACE;
			consume = 1'b1;
		end else if (is_sign) begin
			neg_d = (ch == CH_MINUS);
			ph_d = SC_DIGIT;
			consume = 1'b1;
		end else if (is_digit) begin
			mag_d = {{(VALUE_W-4){1'b0}}, dig};
			ph_d = SC_DIGIT;
			consume = 1'b1;
		end else begin
			done = 1'b1;
		end
	end

	always_comb begin
		if (cmd.take) begin
			raddr = '0;
		end else if (cmd.step && consume) begin
			raddr = pos_q + ADDR_W'(1);
		end else begin
			raddr = pos_q;
		end
	end

	assign stat.line_end = line_end;
	assign stat.scan_done = done;

	assign pct_in = (mag_q >= {{(VALUE_W-8){1'b0}}, pct_low_q})
		&& (mag_q <= {{(VALUE_W-8){1'b0}}, pct_high_q});
	assign val_ok = !(neg_q && (mag_q != '0))
		&& (v_q >= {{(PROD_W-SPEED_W){1'b0}}, pwm_low_q})
		&& (v_q <= {{(PROD_W-SPEED_W){1'b0}}, pwm_high_q});

	always_ff @(posedge clk) begin
		pos_q <= raddr;
		if (cmd.take) begin
			ph_q <= SC_HEAD;
			mag_q <= '0;
			neg_q <= 1'b0;
			nov_q <= 1'b0;
		end else if (cmd.step) begin
			ph_q <= ph_d;
			mag_q <= mag_d;
			neg_q <= neg_d;
			nov_q <= nov_d;
		end
		if (cmd.scale) begin
			v_q <= pct_in ? PROD_W'(mag_q * pct_scale_q) : {8'h00, mag_q};
		end
		if (cmd.load) begin
			drive_o_q <= drive_q;
			pid_o_q <= pid_q;
			horn_o_q <= horn_q;
			link_o_q <= link_q;
			speed_o_q <= speed_q;
			motor_o_q <= motor_p_q;
			buzz_o_q <= buzz_p_q;
			app_o_q <= app_p_q;
			rej_o_q <= rej_p_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_low_q <= 8'd0;
			pct_high_q <= 8'd100;
			pct_scale_q <= 8'd10;
			pwm_low_q <= 16'd0;
			pwm_high_q <= 16'd1000;
			len_q <= '0;
			drive_q <= DRV_STOP;
			pid_q <= 1'b0;
			horn_q <= 1'b0;
			link_q <= 1'b0;
			speed_q <= '0;
			motor_p_q <= 1'b0;
			buzz_p_q <= 1'b0;
			app_p_q <= 1'b0;
			rej_p_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_PCT_LOW:   pct_low_q <= cfg_data[7:0];
					CFG_PCT_HIGH:  pct_high_q <= cfg_data[7:0];
					CFG_PCT_SCALE: pct_scale_q <= cfg_data[7:0];
					CFG_PWM_LOW:   pwm_low_q <= cfg_data[SPEED_W-1:0];
					CFG_PWM_HIGH:  pwm_high_q <= cfg_data[SPEED_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.take) begin
				motor_p_q <= !pid_q && ((rx_byte == CH_F) || (rx_byte == CH_B)
					|| (rx_byte == CH_L) || (rx_byte == CH_R) || (rx_byte == CH_S));
				buzz_p_q <= (rx_byte == CH_S) || (rx_byte == CH_H) || (rx_byte == CH_H_LO);
				app_p_q <= 1'b0;
				rej_p_q <= 1'b0;
				unique case (rx_byte) inside
					CH_F, CH_B, CH_L, CH_R: begin
						if (rx_byte == CH_F) begin
							drive_q <= DRV_FWD;
						end else if (rx_byte == CH_B) begin
							drive_q <= DRV_BACK;
						end else if (rx_byte == CH_L) begin
							drive_q <= DRV_LEFT;
						end else begin
							drive_q <= DRV_RIGHT;
						end
						len_q <= '0;
					end
					CH_S: begin
						drive_q <= DRV_STOP;
						horn_q <= 1'b0;
						len_q <= '0;
					end
					CH_P, CH_P_LO: begin
						pid_q <= (rx_byte == CH_P);
						len_q <= '0;
					end
					CH_H, CH_H_LO: begin
						horn_q <= (rx_byte == CH_H);
						len_q <= '0;
					end
					CH_O, CH_O_LO: begin
						link_q <= (rx_byte == CH_O);
						len_q <= '0;
					end
					CH_CR, CH_LF: begin
						len_q <= len_q;
					end
					default: begin
						if (len_q < LEN_MAX) begin
							len_q <= len_q + ADDR_W'(1);
						end else begin
							len_q <= '0;
						end
					end
				endcase
			end
			if (cmd.check) begin
				len_q <= '0;
				if (!nov_q) begin
					if (val_ok) begin
						speed_q <= v_q[SPEED_W-1:0];
						app_p_q <= 1'b1;
						motor_p_q <= !pid_q;
					end else begin
						rej_p_q <= 1'b1;
					end
				end
			end
		end
	end

	assign drive_command = drive_o_q;
	assign pid_enabled = pid_o_q;
	assign horn_on = horn_o_q;
	assign link_online = link_o_q;
	assign motor_speed = speed_o_q;
	assign motor_refresh = motor_o_q;
	assign buzzer_refresh = buzz_o_q;
	assign speed_applied = app_o_q;
	assign speed_rejected = rej_o_q;

endmodule

### design/rucp_chk.sv
`timescale 1ns / 1ps
// port-level checker for the command parser, bound to the top level
// depends on rover_uart_command_parser_core

module rucp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  drive_command,
	input logic        pid_enabled,
	input logic        motor_refresh,
	input logic        speed_applied,
	input logic        speed_rejected
);

	// a result waits while stalled
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one request at a time: busy right after a request is taken
	ap_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	ap_speed_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(speed_applied && speed_rejected))
		else $error("speed both applied and rejected");

	ap_motor_pid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && motor_refresh |-> !pid_enabled)
		else $error("motor refresh with pid on");

	ap_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_command <= 3'd4))
		else $error("drive command out of range");

endmodule

bind rover_uart_command_parser_core rucp_chk u_rucp_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.drive_command (drive_command),
	.pid_enabled   (pid_enabled),
	.motor_refresh (motor_refresh),
	.speed_applied (speed_applied),
	.speed_rejected(speed_rejected)
);
